[hdl/mvt_pkg.sv]
package mvt_pkg;

  localparam int unsigned FRACTION_BITS = 16;

  localparam int unsigned EntryW  = 32;
  localparam int unsigned Dim     = 4;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned CfgIdxW = $clog2(NumRegs);
  localparam int unsigned CfgW    = 2 * EntryW;

  // full product, product after the fraction shift, pair sum, row sum
  localparam int unsigned FullW = 2 * EntryW;
  localparam int unsigned ProdW = FullW - FRACTION_BITS;
  localparam int unsigned PairW = ProdW + 1;
  localparam int unsigned SumW  = ProdW + 2;

  localparam logic [EntryW-1:0] EntryOne = EntryW'(1) << FRACTION_BITS;

  typedef logic signed [EntryW-1:0] coord_t;
  typedef coord_t [Dim-1:0]         vec_t;
  typedef vec_t [Dim-1:0]           mat_t;   // [row][col]

  typedef logic signed [ProdW-1:0] prod_t;
  typedef prod_t [Dim-1:0]         prod_row_t;
  typedef prod_row_t [Dim-1:0]     prod_arr_t;

  typedef logic signed [PairW-1:0] pair_t;
  typedef pair_t [1:0]             pair_row_t;
  typedef pair_row_t [Dim-1:0]     pair_arr_t;

endpackage

[hdl/mvt_if.sv]
interface mvt_vec_in_if
  import mvt_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t vec_x;
  coord_t vec_y;
  coord_t vec_z;
  coord_t vec_w;

  modport source (output valid, output vec_x, output vec_y, output vec_z, output vec_w,
                  input ready);
  modport sink (input valid, input vec_x, input vec_y, input vec_z, input vec_w,
                output ready);
endinterface

interface mvt_vec_out_if
  import mvt_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  coord_t out_w;

  modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                  input ready);
  modport sink (input valid, input out_x, input out_y, input out_z, input out_w,
                output ready);
endinterface

[hdl/mat4_vector_transform.sv]
// 4x4 matrix times vector in signed Q16.16. Takes one vector per clock while
// the pipeline is not stalled, through three register stages: sixteen 32x32
// multipliers with the fraction shift, a pairwise add, then the final add with
// saturation to 32 bits. Each stage holds its item when the next one is full and
// fills bubbles, so the block keeps taking items while a finished result waits
// at the output, until every stage is full. The matrix sits in eight 64-bit
// registers (two entries each, lower column in the low half) and resets to
// identity; write them only while the pipeline is empty.
module mat4_vector_transform
  import mvt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgW-1:0]      cfg_data_i,
  mvt_vec_in_if.sink           vec_in,
  mvt_vec_out_if.source        vec_out
);

  mat_t      mat;
  vec_t      vec;
  prod_arr_t prod;
  pair_arr_t pair;
  vec_t      res;
  logic      mul_valid, mul_ready;
  logic      pair_valid, pair_ready;
  logic      sum_ready;

  mvt_mat_regs u_mat_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mat_o       (mat)
  );

  assign vec[0] = vec_in.vec_x;
  assign vec[1] = vec_in.vec_y;
  assign vec[2] = vec_in.vec_z;
  assign vec[3] = vec_in.vec_w;

  mvt_mul_stage u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mat_i   (mat),
    .valid_i (vec_in.valid),
    .ready_o (vec_in.ready),
    .vec_i   (vec),
    .valid_o (mul_valid),
    .ready_i (mul_ready),
    .prod_o  (prod)
  );

  mvt_pair_add u_pair (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .ready_o (mul_ready),
    .prod_i  (prod),
    .valid_o (pair_valid),
    .ready_i (pair_ready),
    .pair_o  (pair)
  );

  mvt_sum_sat u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pair_valid),
    .ready_o (pair_ready),
    .pair_i  (pair),
    .valid_o (vec_out.valid),
    .ready_i (vec_out.ready),
    .vec_o   (res)
  );

  assign sum_ready     = pair_ready;
  assign vec_out.out_x = res[0];
  assign vec_out.out_y = res[1];
  assign vec_out.out_z = res[2];
  assign vec_out.out_w = res[3];

`ifndef SYNTHESIS
  // the multiply stage only fills from an accepted item
  a_mul_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mul_valid) |-> $past(vec_in.valid && vec_in.ready))
    else $error("multiply stage filled without an accepted item");

  // input may only be taken while some stage can still move
  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vec_in.ready |-> !(mul_valid && pair_valid && vec_out.valid && !vec_out.ready))
    else $error("item accepted into a full, stalled pipeline");

  // an item leaving the pair stage shows at the output next cycle
  a_pair_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pair_valid && sum_ready) |=> vec_out.valid)
    else $error("item lost between pair add and output");
`endif

endmodule

[hdl/mvt_mat_regs.sv]
module mvt_mat_regs
  import mvt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output mat_t               mat_o
);

  logic [CfgW-1:0] regs_q [NumRegs];

  for (genvar i = 0; i < NumRegs; i++) begin : g_reg
    // register i holds row i/2, columns 2*(i%2) and 2*(i%2)+1
    localparam int unsigned Row  = i / 2;
    localparam int unsigned Half = i % 2;
    localparam logic [CfgW-1:0] RstVal = ((Row / 2) == Half) ?
        ({{EntryW{1'b0}}, EntryOne} << (EntryW * (Row % 2))) : '0;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        regs_q[i] <= RstVal;
      end else if (cfg_we_i && (cfg_index_i == CfgIdxW'(i))) begin
        regs_q[i] <= cfg_data_i;
      end
    end
  end

  for (genvar r = 0; r < Dim; r++) begin : g_row
    for (genvar c = 0; c < Dim; c++) begin : g_col
      assign mat_o[r][c] = regs_q[r * 2 + c / 2][EntryW * (c % 2) +: EntryW];
    end
  end

endmodule

[hdl/mvt_mul_stage.sv]
module mvt_mul_stage
  import mvt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mat_t      mat_i,
  input  logic      valid_i,
  output logic      ready_o,
  input  vec_t      vec_i,
  output logic      valid_o,
  input  logic      ready_i,
  output prod_arr_t prod_o
);

  logic      valid_q;
  prod_arr_t prod_d;
  prod_arr_t prod_q;

  assign ready_o = !valid_q || ready_i;

  for (genvar r = 0; r < Dim; r++) begin : g_row
    for (genvar c = 0; c < Dim; c++) begin : g_col
      logic signed [FullW-1:0] full;
      assign full = $signed(mat_i[r][c]) * $signed(vec_i[c]);
      // arithmetic shift = floor; just drop the fraction bits
      assign prod_d[r][c] = full[FullW-1:FRACTION_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

[hdl/mvt_pair_add.sv]
module mvt_pair_add
  import mvt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  prod_arr_t prod_i,
  output logic      valid_o,
  input  logic      ready_i,
  output pair_arr_t pair_o
);

  logic      valid_q;
  pair_arr_t pair_d;
  pair_arr_t pair_q;

  assign ready_o = !valid_q || ready_i;

  for (genvar r = 0; r < Dim; r++) begin : g_row
    for (genvar h = 0; h < 2; h++) begin : g_half
      assign pair_d[r][h] = {prod_i[r][2*h][ProdW-1], prod_i[r][2*h]}
                          + {prod_i[r][2*h+1][ProdW-1], prod_i[r][2*h+1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pair_q <= pair_d;
    end
  end

  assign valid_o = valid_q;
  assign pair_o  = pair_q;

endmodule

[hdl/mvt_sum_sat.sv]
module mvt_sum_sat
  import mvt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  pair_arr_t pair_i,
  output logic      valid_o,
  input  logic      ready_i,
  output vec_t      vec_o
);

  localparam logic [EntryW-1:0] SatMax = {1'b0, {(EntryW-1){1'b1}}};
  localparam logic [EntryW-1:0] SatMin = {1'b1, {(EntryW-1){1'b0}}};

  logic valid_q;
  vec_t vec_d;
  vec_t vec_q;

  assign ready_o = !valid_q || ready_i;

  for (genvar r = 0; r < Dim; r++) begin : g_row
    logic signed [SumW-1:0] sum;
    logic                   fits;
    assign sum = {pair_i[r][0][PairW-1], pair_i[r][0]}
               + {pair_i[r][1][PairW-1], pair_i[r][1]};
    // in range when every bit above the 32-bit sign equals it
    assign fits = (&sum[SumW-1:EntryW-1]) || !(|sum[SumW-1:EntryW-1]);
    assign vec_d[r] = fits ? sum[EntryW-1:0] : (sum[SumW-1] ? SatMin : SatMax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

[dv/mat4_vector_transform_test.sv]
module mat4_vector_transform_test;
  import mvt_pkg::*;

  localparam int ClkHalf      = 5;
  localparam int ResetCycles  = 12;
  localparam int PipeLatency  = 3;
  localparam int StallLimit   = 2000;
  localparam int HoldCycles   = 64;
  localparam int MaxReported  = 40;
  localparam int RandomPhases = 8;
  localparam int PhaseItems   = 105;

  localparam longint SumMax = 64'sh7FFF_FFFF;
  localparam longint SumMin = -64'sh8000_0000;

  localparam coord_t CoordMax    = 32'h7FFF_FFFF;
  localparam coord_t CoordMin    = 32'h8000_0000;
  localparam coord_t CoordNegOne = 32'hFFFF_FFFF;
  localparam coord_t CoordOne    = EntryOne;
  localparam coord_t CoordMinus1 = -EntryOne;

  typedef enum int {
    MatIdentity,
    MatSmallRandom,
    MatFullRandom,
    MatMaxEntries,
    MatMinEntries,
    MatAllOnesBits
  } mat_kind_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_data_i  = '0;

  mvt_vec_in_if  vec_in_ch ();
  mvt_vec_out_if vec_out_ch ();

  mat4_vector_transform dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .vec_in  (vec_in_ch),
    .vec_out (vec_out_ch)
  );

  mat_t cur_matrix;
  vec_t expected_vecs[$];
  int   send_idle_pct;
  int   recv_stall_pct;
  int   recv_hold_left;
  int   items_sent;
  int   results_checked;
  int   mismatch_count;
  int   matrices_loaded;
  int   quiet_cycles;

  always #ClkHalf clk_i = ~clk_i;

  // rows of the matrix dotted with the vector; every product floors, the row sum saturates
  function automatic vec_t transform_vec(input mat_t m, input vec_t v);
    vec_t   res;
    longint acc;
    int     row;
    int     col;
    for (row = 0; row < Dim; row++) begin
      acc = 0;
      for (col = 0; col < Dim; col++)
        acc += (longint'($signed(m[row][col])) * longint'($signed(v[col]))) >>> FRACTION_BITS;
      if (acc > SumMax) res[row] = coord_t'(SumMax);
      else if (acc < SumMin) res[row] = coord_t'(SumMin);
      else res[row] = coord_t'(acc);
    end
    return res;
  endfunction

  function automatic vec_t mk_vec(input coord_t x, input coord_t y, input coord_t z,
                                  input coord_t w);
    vec_t v;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    v[3] = w;
    return v;
  endfunction

  // about +-4.0
  function automatic coord_t rand_small();
    return coord_t'(int'($urandom_range(524287)) - 262144);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(7))
      0, 1: return coord_t'($urandom);
      2: begin
        case ($urandom_range(5))
          0: return CoordMax;
          1: return CoordMin;
          2: return '0;
          3: return CoordNegOne;
          4: return CoordOne;
          default: return CoordMinus1;
        endcase
      end
      3: return coord_t'(int'($urandom_range(255)) - 128);
      4: return coord_t'(int'($urandom_range(33554431)) - 16777216);
      default: return rand_small();
    endcase
  endfunction

  function automatic vec_t rand_vec();
    vec_t v;
    int   i;
    for (i = 0; i < Dim; i++)
      v[i] = rand_coord();
    // usual homogeneous point
    if ($urandom_range(3) == 0) v[3] = CoordOne;
    return v;
  endfunction

  function automatic mat_t uniform_matrix(input coord_t val);
    mat_t m;
    int   row;
    int   col;
    for (row = 0; row < Dim; row++)
      for (col = 0; col < Dim; col++)
        m[row][col] = val;
    return m;
  endfunction

  function automatic mat_t build_matrix(input mat_kind_e kind);
    mat_t m;
    int   row;
    int   col;
    for (row = 0; row < Dim; row++) begin
      for (col = 0; col < Dim; col++) begin
        case (kind)
          MatIdentity:    m[row][col] = (row == col) ? CoordOne : coord_t'(0);
          MatSmallRandom: m[row][col] = rand_small();
          MatFullRandom:  m[row][col] = coord_t'($urandom);
          MatMaxEntries:  m[row][col] = CoordMax;
          MatMinEntries:  m[row][col] = CoordMin;
          default:        m[row][col] = CoordNegOne;
        endcase
      end
    end
    return m;
  endfunction

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic send_vec(input vec_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      vec_in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    vec_in_ch.valid <= 1'b1;
    vec_in_ch.vec_x <= v[0];
    vec_in_ch.vec_y <= v[1];
    vec_in_ch.vec_z <= v[2];
    vec_in_ch.vec_w <= v[3];
    do @(posedge clk_i); while (!vec_in_ch.ready);
  endtask

  task automatic send_random(input int count);
    int n;
    for (n = 0; n < count; n++)
      send_vec(rand_vec());
  endtask

  // step past the current edge first, so the item taken there is already queued
  task automatic wait_results();
    do @(posedge clk_i); while (expected_vecs.size() != 0);
  endtask

  task automatic settle_pipeline();
    vec_in_ch.valid <= 1'b0;
    wait_results();
    repeat (PipeLatency + 1) @(posedge clk_i);
  endtask

  task automatic write_reg(input int idx, input logic [CfgW-1:0] data);
    int row;
    int col;
    row = idx / 2;
    col = (idx % 2) * 2;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgIdxW'(idx);
    cfg_data_i  <= data;
    @(posedge clk_i);
    cur_matrix[row][col]     = data[EntryW-1:0];
    cur_matrix[row][col + 1] = data[CfgW-1:EntryW];
  endtask

  // lower column of each pair goes in the low half
  task automatic load_matrix(input mat_t m);
    int idx;
    settle_pipeline();
    for (idx = 0; idx < NumRegs; idx++)
      write_reg(idx, {m[idx / 2][(idx % 2) * 2 + 1], m[idx / 2][(idx % 2) * 2]});
    cfg_we_i <= 1'b0;
    matrices_loaded++;
  endtask

  // no register written yet: the block must come out of reset as identity
  task automatic check_identity_passthrough();
    set_idling(0, 0);
    send_vec(mk_vec('0, '0, '0, '0));
    send_vec(mk_vec(CoordMax, CoordMin, 32'sd1, CoordNegOne));
    send_vec(mk_vec(CoordOne, CoordMinus1, 32'h1234_5678, 32'hFEDC_BA98));
  endtask

  task automatic check_floor_rounding();
    // smallest positive entry: each product is floor(v / 2^16)
    load_matrix(uniform_matrix(32'sd1));
    send_vec(mk_vec(CoordNegOne, CoordNegOne, CoordNegOne, CoordNegOne));
    send_vec(mk_vec(32'sd1, 32'sd1, 32'sd1, 32'sd1));
    send_vec(mk_vec(32'sd65535, -32'sd65535, 32'sd65537, -32'sd65537));
    // one half: +1.5 floors to 1, -1.5 floors to -2
    load_matrix(uniform_matrix(32'h0000_8000));
    send_vec(mk_vec(32'sd3, -32'sd3, 32'sd1, CoordNegOne));
  endtask

  task automatic check_saturation_bounds();
    mat_t m;
    int   row;
    // out[r] = v[r] + v[(r+1)%4], so sums land exactly on and just past each limit
    m = uniform_matrix('0);
    for (row = 0; row < Dim; row++) begin
      m[row][row]           = CoordOne;
      m[row][(row + 1) % 4] = CoordOne;
    end
    load_matrix(m);
    send_vec(mk_vec(CoordMax, '0, CoordMin, '0));
    send_vec(mk_vec(CoordMax, 32'sd1, CoordMin, CoordNegOne));
    send_vec(mk_vec(CoordMax, CoordMin, CoordMax, CoordMin));
    send_vec(mk_vec(CoordMin, CoordMin, CoordMin, CoordMin));
  endtask

  task automatic check_extreme_matrices();
    load_matrix(build_matrix(MatMaxEntries));
    send_vec(mk_vec(CoordMax, CoordMax, CoordMax, CoordMax));
    send_vec(mk_vec(CoordMin, CoordMin, CoordMin, CoordMin));
    load_matrix(build_matrix(MatMinEntries));
    send_vec(mk_vec(CoordMin, CoordMin, CoordMin, CoordMin));
    send_vec(mk_vec(CoordMax, CoordMin, 32'sd1, CoordNegOne));
    load_matrix(build_matrix(MatAllOnesBits));
    send_vec(mk_vec(CoordMin, CoordMax, CoordOne, '0));
  endtask

  task automatic check_random_streams();
    mat_kind_e kinds[RandomPhases];
    int        phase;
    kinds = '{MatSmallRandom, MatFullRandom, MatIdentity, MatSmallRandom,
              MatMaxEntries, MatFullRandom, MatMinEntries, MatSmallRandom};
    for (phase = 0; phase < RandomPhases; phase++) begin
      load_matrix(build_matrix(kinds[phase]));
      case (phase % 4)
        0: set_idling(0, 0);
        1: set_idling(54, 0);
        2: set_idling(0, 54);
        default: set_idling(24, 24);
      endcase
      send_random(PhaseItems);
    end
  endtask

  // output held off while input keeps coming: the pipeline fills and stalls its input
  task automatic check_output_backpressure();
    load_matrix(build_matrix(MatSmallRandom));
    set_idling(0, 0);
    recv_hold_left = HoldCycles;
    send_random(40);
  endtask

  task automatic check_drain_pause();
    set_idling(24, 24);
    send_random(25);
    vec_in_ch.valid <= 1'b0;
    wait_results();
    send_random(25);
  endtask

  // output side: random ready pattern, with a long hold when a test asks for one
  initial begin
    vec_out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        vec_out_ch.ready <= 1'b0;
      end else if (recv_hold_left > 0) begin
        vec_out_ch.ready <= 1'b0;
        recv_hold_left--;
      end else begin
        vec_out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // results are checked before the same edge's input is predicted
  always @(posedge clk_i) begin
    vec_t got;
    vec_t want;
    vec_t taken;
    bit   moved;
    int   fld;
    moved = 1'b0;
    if (rst_ni && vec_out_ch.valid && vec_out_ch.ready) begin
      moved  = 1'b1;
      got[0] = vec_out_ch.out_x;
      got[1] = vec_out_ch.out_y;
      got[2] = vec_out_ch.out_z;
      got[3] = vec_out_ch.out_w;
      if (expected_vecs.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no item pending: expected none, got %h %h %h %h",
                 $time, got[0], got[1], got[2], got[3]);
      end else begin
        want = expected_vecs.pop_front();
        results_checked++;
        for (fld = 0; fld < Dim; fld++) begin
          if (got[fld] !== want[fld]) begin
            mismatch_count++;
            if (mismatch_count <= MaxReported)
              $display("%0t: output component %0d: expected %h, got %h",
                       $time, fld, want[fld], got[fld]);
          end
        end
      end
    end
    if (rst_ni && vec_in_ch.valid && vec_in_ch.ready) begin
      moved    = 1'b1;
      taken[0] = vec_in_ch.vec_x;
      taken[1] = vec_in_ch.vec_y;
      taken[2] = vec_in_ch.vec_z;
      taken[3] = vec_in_ch.vec_w;
      expected_vecs.push_back(transform_vec(cur_matrix, taken));
      items_sent++;
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < StallLimit) @(posedge clk_i);
    $display("%0t: timeout, no item moved for %0d cycles", $time, StallLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    cur_matrix = build_matrix(MatIdentity);
    vec_in_ch.valid <= 1'b0;
    vec_in_ch.vec_x <= '0;
    vec_in_ch.vec_y <= '0;
    vec_in_ch.vec_z <= '0;
    vec_in_ch.vec_w <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_identity_passthrough();
    check_floor_rounding();
    check_saturation_bounds();
    check_extreme_matrices();
    check_random_streams();
    check_output_backpressure();
    check_drain_pause();
    settle_pipeline();

    $display("Sent %0d vectors through %0d loaded matrices; %0d results compared, %0d bad.",
             items_sent, matrices_loaded, results_checked, mismatch_count);
    $display("Covered reset identity, floor rounding, both saturation limits, idle/stall mixes.");
    if (mismatch_count == 0 && expected_vecs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
